### src/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// Used by deq_ctrl, deq_dp, deq_checker and the top level; no dependencies.
package deq_pkg;

   // Operation codes carried in req_tuser
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_DUMP       = 3'd4
   } op_type;

   // Result status carried in rsp_tuser
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_RESP
   } state_type;

   localparam int WORD_W = 32;
   localparam int OP_W   = 3;

   // Controller -> datapath
   typedef struct packed {
      logic accept;   // latch the incoming transfer
      logic exec;     // carry out the latched operation
      logic capture;  // load the registered RAM read into the result
      logic advance;  // step the dump offset
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic is_push;
      logic is_pop;
      logic is_dump;
      logic empty;
      logic dump_more;  // a dump result is shown and more words follow
   } sts_type;

endpackage

### src/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### src/deq_ctrl.sv
// Sequencing state machine for the double-ended queue.
// Depends on deq_pkg.
module deq_ctrl
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if ((sts.is_pop || sts.is_dump) && !sts.empty) begin
               state_in = S_READ;
            end else if (sts.is_push || sts.is_pop || sts.is_dump) begin
               state_in = S_RESP;
            end else begin
               state_in = S_IDLE;   // unused code: no result
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = sts.dump_more ? S_EXEC : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_READ: begin
            cmd.capture = 1'b1;
         end
         S_RESP: begin
            rsp_tvalid  = 1'b1;
            cmd.advance = rsp_tready && sts.dump_more;
         end
         default: ;
      endcase
   end

endmodule

### src/deq_dp.sv
// Datapath: head/count registers, ring index math, ring RAM and result register.
// Depends on deq_pkg and deq_ram.
module deq_dp
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [OP_W-1:0]   in_op,
   input  logic [WORD_W-1:0] in_value,
   output logic [1:0]        out_status,
   output logic [WORD_W-1:0] out_word,
   output logic              out_last
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [IW-1:0] TOP_IX  = IW'(DEPTH - 1);

   logic [OP_W-1:0]   op_ff;
   logic [WORD_W-1:0] value_ff;
   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     offset_ff, offset_in;
   logic [1:0]        status_ff, status_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              last_ff, last_in;

   logic              wr_en, rd_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              full, empty, is_push, is_pop, is_dump, dump_end;

   // (h + off) mod DEPTH; the sum stays below twice DEPTH
   function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] h,
                                              input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW + 1)'(h) + {1'b0, off};
      if (s >= DEPTH_S) s = s - DEPTH_S;
      return s[IW-1:0];
   endfunction

   assign full     = (count_ff == DEPTH_C);
   assign empty    = (count_ff == '0);
   assign is_push  = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_REAR);
   assign is_pop   = (op_ff == OP_POP_FRONT) || (op_ff == OP_POP_REAR);
   assign is_dump  = (op_ff == OP_DUMP);
   assign dump_end = ((offset_ff + 1'b1) == count_ff);

   assign sts.is_push   = is_push;
   assign sts.is_pop    = is_pop;
   assign sts.is_dump   = is_dump;
   assign sts.empty     = empty;
   assign sts.dump_more = is_dump && !last_ff;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      status_in = status_ff;
      word_in   = word_ff;
      last_in   = last_ff;
      wr_en     = 1'b0;
      wr_addr   = ring_pos(head_ff, count_ff);
      rd_en     = 1'b0;
      rd_addr   = head_ff;

      if (cmd.accept) begin
         offset_in = '0;
      end

      if (cmd.exec) begin
         word_in   = '0;
         last_in   = 1'b1;
         status_in = ST_OK;
         case (op_ff)
            OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  head_in  = (head_ff == '0) ? TOP_IX : head_ff - 1'b1;
                  wr_addr  = head_in;
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_REAR: begin
               if (full) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  rd_en    = 1'b1;
                  head_in  = ring_pos(head_ff, CW'(1));
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_REAR: begin
               if (empty) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = ring_pos(head_ff, count_ff - 1'b1);
                  count_in = count_ff - 1'b1;
               end
            end
            OP_DUMP: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ring_pos(head_ff, offset_ff);
               end
            end
            default: ;
         endcase
      end

      if (cmd.capture) begin
         status_in = ST_OK;
         word_in   = rd_data;
         last_in   = is_pop || dump_end;
      end

      if (cmd.advance) begin
         offset_in = offset_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= in_op;
         value_ff <= in_value;
      end
      offset_ff <= offset_in;
      status_ff <= status_in;
      word_ff   <= word_in;
      last_ff   <= last_in;
   end

   deq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_status = status_ff;
   assign out_word   = word_ff;
   assign out_last   = last_ff;

endmodule

### src/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words, ring store in a RAM.
// Each request transfer carries one operation in req_tuser (push front, push
// rear, pop front, pop rear, dump) and the word to push in req_tdata. Push and
// pop give exactly one response transfer with rsp_tlast set; a pop returns the
// removed word. Dump streams the stored words front to rear and sets rsp_tlast
// on the rear word; an empty dump gives one response with status empty. Pops
// on an empty queue report underflow, pushes on a full queue report overflow
// and change nothing. Codes five to seven are dropped with no response.
// One request is in flight at a time. A request passes through the accept
// and execute states, then, unless its code is dropped, the response state,
// with a RAM read state before it for each word fetched (a pop that returns
// a word, each dumped word); a dump goes back from response to execute for
// each further word, and the response state holds while the response side
// stalls. The next request is taken the cycle after the last response
// transfer. The RAM read state comes from the RAM's registered read, and the
// controller returns to idle between requests.
// Reset is synchronous and takes the queue to empty; RAM contents need no
// clearing, since only entries that hold queued words are ever read.
// Depends on deq_pkg, deq_ctrl, deq_dp and deq_ram.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 16   // 2 .. 64 entries
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] op
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] word
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last response of the request
);

   cmd_type cmd;
   sts_type sts;

   // controller: sequences accept, execute, RAM read and response
   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: head/count, ring arithmetic, RAM and the response register
   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_op      (req_tuser),
      .in_value   (req_tdata),
      .out_status (rsp_tuser),
      .out_word   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

### src/deq_checker.sv
// Port-level checks for double_ended_queue, bound to the top level.
// Depends on deq_pkg.
module deq_checker
   import deq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // one request at a time: no request taken while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready while response pending");

   // error and empty statuses end the request
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tlast)
      else $error("non-ok status without last");

   // error and empty statuses carry no word
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("non-ok status with nonzero word");

   // a request taken cannot show its response in the very next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("response too early");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
